### rtl/core/first_fit_segment_allocator_defines.svh
// ----------------------------------------------------------------------------
// Segment allocator assertion macros
// Property checks that vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFSA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define FFSA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define FFSA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define FFSA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### rtl/core/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;
  localparam int unsigned MaxSegmentsDef = 32;
  localparam int unsigned AddrBitsDef    = 16;
  localparam logic [15:0] PoolResetVal   = 16'd1024;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_LIST   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_ALLOC_OK   = 3'd0;
  localparam logic [2:0] ST_ALLOC_FAIL = 3'd1;
  localparam logic [2:0] ST_FREE_OK    = 3'd2;
  localparam logic [2:0] ST_FREE_FAIL  = 3'd3;
  localparam logic [2:0] ST_FREE_SEG   = 3'd4;
  localparam logic [2:0] ST_NONE_FREE  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] seg_start;
    logic [15:0] seg_end;
    logic        last;
  } out_item_t;
endpackage
`default_nettype wire

### rtl/core/ffsa_cell.sv
// ----------------------------------------------------------------------------
// Segment table cell
// Holds one segment and takes part in chain-wide shifts toward the head,
// away from it, and the rebuild and write-back commands.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsa_cell #(
  parameter int unsigned AW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rebuild,
  input  wire logic [AW-1:0] rebuild_end,
  input  wire logic          is_head,
  input  wire logic          shift_up,
  input  wire logic          shift_dn,
  input  wire logic [AW-1:0] prev_start,
  input  wire logic [AW-1:0] prev_end,
  input  wire logic          prev_used,
  input  wire logic [AW-1:0] next_start,
  input  wire logic [AW-1:0] next_end,
  input  wire logic          next_used,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_start,
  input  wire logic [AW-1:0] wr_end,
  input  wire logic          wr_used,
  output logic [AW-1:0]      seg_start,
  output logic [AW-1:0]      seg_end,
  output logic               seg_used
);
  logic [AW-1:0] start_r, end_r;
  logic          used_r;

  // Priority: rebuild, direct write, then shifts.
  always_ff @(posedge clk) begin
    if (!rst_n || rebuild) begin
      start_r <= '0;
      end_r   <= is_head ? rebuild_end : '0;
      used_r  <= 1'b0;
    end else if (wr_en) begin
      start_r <= wr_start;
      end_r   <= wr_end;
      used_r  <= wr_used;
    end else if (shift_up) begin
      start_r <= next_start;
      end_r   <= next_end;
      used_r  <= next_used;
    end else if (shift_dn) begin
      start_r <= prev_start;
      end_r   <= prev_end;
      used_r  <= prev_used;
    end
  end

  assign seg_start = start_r;
  assign seg_end   = end_r;
  assign seg_used  = used_r;
endmodule
`default_nettype wire

### rtl/core/first_fit_segment_allocator.sv
// Scan: the scan unit looks at one table entry per cycle; busy stays high from an accepted
// transaction until its scan and any split and merge steps are done, and the last result
// strobes in the final or the next-to-last busy cycle.
// Throughput: one transaction in flight; the next is accepted at the first edge after busy
// falls. Results cannot be stalled. Synchronous reset restores one free segment [0,1024).
`default_nettype none
module first_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef,
  parameter int unsigned ADDR_BITS    = ffsa_pkg::AddrBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ffsa_pkg::in_item_t in_item,
  output logic                    out_strobe,
  output ffsa_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_pool_size
);
  import ffsa_pkg::*;
`include "first_fit_segment_allocator_defines.svh"

  localparam int unsigned N  = MAX_SEGMENTS;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned AW = ADDR_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHDN  = 7'b0000100,
    S_SPLIT = 7'b0001000,
    S_MERGE = 7'b0010000,
    S_SHUP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    func_r;
  logic [AW-1:0] amt_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] pool_r;
  logic          found_r;
  logic [AW-1:0] cut_r;

  logic [AW-1:0] c_start [N];
  logic [AW-1:0] c_end   [N];
  logic          c_used  [N];
  logic          shift_up_en, shift_dn_en, rebuild;
  logic          wr_en;
  logic [AW-1:0] wr_start, wr_end;
  logic          wr_used;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] sh_idx;

  // Current entry seen by the scan unit.
  logic [AW-1:0] cur_start, cur_end, cur_len;
  logic          cur_used, at_end;
  assign cur_start = c_start[idx_r];
  assign cur_end   = c_end[idx_r];
  assign cur_used  = c_used[idx_r];
  assign cur_len   = cur_end - cur_start;
  assign at_end    = ({1'b0, idx_r} >= count_r);

  logic [IW:0] idx_p1;
  assign idx_p1 = {1'b0, idx_r} + 1'b1;

  // Cell chain.
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned GP = (g == 0) ? 0 : g - 1;
    localparam int unsigned GN = (g == N - 1) ? N - 1 : g + 1;
    logic up_here, dn_here;
    assign up_here = shift_up_en && (g[IW:0] >= {1'b0, sh_idx});
    assign dn_here = shift_dn_en && (g[IW:0] > {1'b0, sh_idx});
    ffsa_cell #(.AW(AW)) u_cell (
      .clk, .rst_n,
      .rebuild     (rebuild),
      .rebuild_end (rst_n ? pool_r : AW'(PoolResetVal)),
      .is_head     (g == 0),
      .shift_up    (up_here),
      .shift_dn    (dn_here),
      .prev_start  (c_start[GP]),
      .prev_end    (c_end[GP]),
      .prev_used   (c_used[GP]),
      .next_start  ((g == N - 1) ? '0 : c_start[GN]),
      .next_end    ((g == N - 1) ? '0 : c_end[GN]),
      .next_used   ((g == N - 1) ? 1'b0 : c_used[GN]),
      .wr_en       (wr_en && (wr_idx == g[IW-1:0])),
      .wr_start, .wr_end, .wr_used,
      .seg_start   (c_start[g]),
      .seg_end     (c_end[g]),
      .seg_used    (c_used[g])
    );
  end

  // A config write never shares an edge with an accepted command.
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // Pool register; reset and config writes rebuild the table.
  logic cfg_fire;
  assign cfg_fire = cfg_valid && cfg_ready;
  logic rebuild_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r    <= AW'(PoolResetVal);
      rebuild_r <= 1'b0;
    end else begin
      rebuild_r <= cfg_fire;
      if (cfg_fire) pool_r <= AW'(cfg_pool_size);
    end
  end
  assign rebuild = rebuild_r;

  // Control sequencer.
  out_item_t     res;
  logic          res_v;
  logic [IW-1:0] idx_nxt;
  logic [CW-1:0] count_nxt;
  logic          found_nxt;
  logic [AW-1:0] cut_nxt;
  logic [AW-1:0] split_end;
  logic          accept;
  assign accept    = start && !busy;
  assign split_end = cur_start + amt_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    found_nxt   = found_r;
    cut_nxt     = cut_r;
    res         = '0;
    res_v       = 1'b0;
    shift_up_en = 1'b0;
    shift_dn_en = 1'b0;
    sh_idx      = idx_r;
    wr_en       = 1'b0;
    wr_idx      = idx_r;
    wr_start    = cur_start;
    wr_end      = cur_end;
    wr_used     = cur_used;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.func != FUNC_UNUSED) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        case (func_r)
          FUNC_ALLOC: begin
            if (amt_r == '0 || at_end) begin
              res_v = 1'b1;
              res.status = ST_ALLOC_FAIL;
              res.last = 1'b1;
              state_nxt = S_DONE;
            end else if (!cur_used && cur_len == amt_r) begin
              wr_en = 1'b1;
              wr_used = 1'b1;
              res_v = 1'b1;
              res.status = ST_ALLOC_OK;
              res.seg_start = 16'(cur_start);
              res.last = 1'b1;
              state_nxt = S_DONE;
            end else if (!cur_used && cur_len > amt_r) begin
              if (count_r == CW'(N)) begin
                res_v = 1'b1;
                res.status = ST_ALLOC_FAIL;
                res.last = 1'b1;
                state_nxt = S_DONE;
              end else begin
                // Open a slot: entries at idx and above move one place down.
                shift_dn_en = 1'b1;
                count_nxt = count_r + 1'b1;
                cut_nxt = split_end;
                state_nxt = S_SPLIT;
              end
            end else begin
              idx_nxt = idx_p1[IW-1:0];
              if (idx_p1 == (IW+1)'(N)) begin
                res_v = 1'b1;
                res.status = ST_ALLOC_FAIL;
                res.last = 1'b1;
                state_nxt = S_DONE;
              end
            end
          end
          FUNC_FREE: begin
            if (at_end) begin
              res_v = 1'b1;
              res.status = ST_FREE_FAIL;
              res.last = 1'b1;
              state_nxt = S_DONE;
            end else if (cur_used && cur_len == amt_r) begin
              wr_en = 1'b1;
              wr_used = 1'b0;
              state_nxt = S_MERGE;
            end else begin
              idx_nxt = idx_p1[IW-1:0];
              if (idx_p1 == (IW+1)'(N)) begin
                res_v = 1'b1;
                res.status = ST_FREE_FAIL;
                res.last = 1'b1;
                state_nxt = S_DONE;
              end
            end
          end
          default: begin
            // List: walk the live entries up to the last free one, one result per free segment.
            if (!at_end && !cur_used) begin
              res_v = 1'b1;
              res.status = ST_FREE_SEG;
              res.seg_start = 16'(cur_start);
              res.seg_end = 16'(cur_end);
              found_nxt = 1'b1;
            end
            begin : list_tail
              logic more;
              more = 1'b0;
              for (int k = 0; k < N; k++) begin
                if (k > int'(idx_r) && k < int'(count_r) && !c_used[k]) more = 1'b1;
              end
              if (at_end || !more) begin
                if (res_v) res.last = 1'b1;
                else if (!found_r) begin
                  res_v = 1'b1;
                  res.status = ST_NONE_FREE;
                  res.last = 1'b1;
                end
                state_nxt = S_DONE;
              end else begin
                idx_nxt = idx_p1[IW-1:0];
              end
            end
          end
        endcase
      end
      S_SPLIT: begin
        // Entry idx is a copy of the old segment; trim it and the next one.
        wr_en = 1'b1;
        wr_end = cut_r;
        wr_used = 1'b1;
        res_v = 1'b1;
        res.status = ST_ALLOC_OK;
        res.seg_start = 16'(cur_start);
        res.last = 1'b1;
        state_nxt = S_SHUP;
      end
      S_SHUP: begin
        wr_en = 1'b1;
        wr_idx = idx_p1[IW-1:0];
        wr_start = cut_r;
        wr_end = c_end[idx_p1[IW-1:0]];
        wr_used = 1'b0;
        state_nxt = S_DONE;
      end
      S_MERGE: begin
        // Absorb one following free segment per cycle.
        if (idx_p1 < (IW+1)'(count_r) && !c_used[idx_p1[IW-1:0]]) begin
          wr_en = 1'b1;
          wr_end = c_end[idx_p1[IW-1:0]];
          sh_idx = idx_p1[IW-1:0];
          shift_up_en = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          res_v = 1'b1;
          res.status = ST_FREE_OK;
          res.last = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Entries above count hold zero; shifting up brings zero into the tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= CW'(1);
      idx_r      <= '0;
      found_r    <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      count_r    <= rebuild ? CW'(1) : count_nxt;
      found_r    <= found_nxt;
      out_strobe <= res_v;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cut_r    <= cut_nxt;
    out_item <= res;
    if (accept) begin
      func_r <= in_item.func;
      amt_r  <= AW'(in_item.amount);
    end
  end

  `FFSA_ASSERT_NXT(a_cfg_idle, clk, rst_n, cfg_fire, !out_strobe, "result after config write")
  `FFSA_ASSERT_IMP(a_count_rng, clk, rst_n, 1'b1, count_r >= CW'(1) && count_r <= CW'(N), "segment count out of range")
  `FFSA_ASSERT_IMP(a_no_strobe_idle, clk, rst_n, state_r == S_IDLE && out_strobe, $past(state_r) == S_DONE || $past(state_r) == S_IDLE, "stray result")
  `FFSA_ASSERT_NXT(a_split_grows, clk, rst_n, state_r == S_SPLIT, count_r == $past(count_r), "count changed in split")
endmodule
`default_nettype wire
